// ----- rtl/core/tbc_pkg.sv -----
`timescale 1ns / 1ps

package tbc_pkg;

  localparam int VOLT_W  = 18;
  localparam int COEF_W  = 48;
  localparam int TEMP_W  = 19;
  localparam int IDX_W   = 3;

  localparam int COEF_FRAC_BITS_DEF = 48;
  localparam int TEMP_FRAC_BITS_DEF = 8;

  // log2 in Q28: 5 bit integer part, 28 bit fraction, Q30 mantissa in [1,2)
  localparam int LOG_FRAC = 28;
  localparam int K_W      = 5;
  localparam int MANT_W   = 31;
  localparam int LOG_W    = K_W + LOG_FRAC;

  localparam logic [31:0] LN2_Q28 = 32'd186065279;

  // horner products: 63 bit magnitude, 33 bit signed multiplier
  localparam int MAG_W = 63;
  localparam int X_W   = 33;
  localparam logic [MAG_W-1:0] MAG_LIM = MAG_W'(1) << 62;

  localparam int QUOT_W = 40;

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sd262143;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -19'sd65536;

  localparam logic [VOLT_W-1:0] SUPPLY_RST = 18'd117572;
  localparam logic signed [COEF_W-1:0] COEF_A_RST = 48'sd944071575487;
  localparam logic signed [COEF_W-1:0] COEF_B_RST = 48'sd72334846890;
  localparam logic signed [COEF_W-1:0] COEF_C_RST = 48'sd737501313;
  localparam logic signed [COEF_W-1:0] COEF_D_RST = 48'sd17966804;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_HIGH = 2'd1,
    FAULT_ZERO = 2'd2,
    FAULT_SAT  = 2'd3
  } tbc_fault_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_SUPPLY  = 3'd0,
    CFG_REF_RES = 3'd1,
    CFG_COEF_A  = 3'd2,
    CFG_COEF_B  = 3'd3,
    CFG_COEF_C  = 3'd4,
    CFG_COEF_D  = 3'd5
  } tbc_cfg_idx_t;

  typedef struct packed {
    logic       valid;
    tbc_fault_t code;
  } tbc_tag_t;

  typedef struct packed {
    logic [K_W-1:0]      k;
    logic [LOG_FRAC-1:0] frac;
    logic [MANT_W-1:0]   m;
  } tbc_log_t;

  typedef struct packed {
    logic [MAG_W-1:0]  r;
    logic [MAG_W-1:0]  d;
    logic [QUOT_W-1:0] q;
    logic              sat;
  } tbc_div_t;

endpackage

// ----- rtl/core/tbc_in_if.sv -----
`timescale 1ns / 1ps

interface tbc_in_if;
  import tbc_pkg::*;
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] bridge_voltage;

  modport source (output valid, output bridge_voltage, input ready);
  modport sink (input valid, input bridge_voltage, output ready);
endinterface

// ----- rtl/core/tbc_out_if.sv -----
`timescale 1ns / 1ps

interface tbc_out_if;
  import tbc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_q8;
  logic [1:0]               fault;

  modport source (output valid, output temperature_q8, output fault, input ready);
  modport sink (input valid, input temperature_q8, input fault, output ready);
endinterface

// ----- rtl/core/thermistor_bridge_to_celsius.sv -----
`timescale 1ns / 1ps
// throughput: one transfer per cycle in and out when not held, set by one cell per pipeline step
// the whole pipeline holds only when its last step has a result and the output register is full
// reset (synchronous, active high) empties the pipeline and loads the default supply and
// coefficients; no clearing pass is needed
module thermistor_bridge_to_celsius
  import tbc_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [COEF_W-1:0] wr_data,
  tbc_in_if.sink            sample,
  tbc_out_if.source         result
);

  // division runs over each bit of the 2^(coef+temp+1) dividend, the last one for rounding
  localparam int DIV_STEPS = COEF_FRAC_BITS + TEMP_FRAC_BITS + 2;
  localparam logic signed [41:0] KELVIN_OFF =
    42'(((64'd27315 << TEMP_FRAC_BITS) + 64'd50) / 64'd100);

  // configuration: the reference resistance cancels out of ln(R/Rref), so it is not kept
  logic [VOLT_W-1:0]        supply;
  logic signed [COEF_W-1:0] coef_a, coef_b, coef_c, coef_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      supply <= SUPPLY_RST;
      coef_a <= COEF_A_RST;
      coef_b <= COEF_B_RST;
      coef_c <= COEF_C_RST;
      coef_d <= COEF_D_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_SUPPLY:  supply <= wr_data[VOLT_W-1:0];
        CFG_REF_RES: ;  // accepted and dropped
        CFG_COEF_A:  coef_a <= wr_data;
        CFG_COEF_B:  coef_b <= wr_data;
        CFG_COEF_C:  coef_c <= wr_data;
        CFG_COEF_D:  coef_d <= wr_data;
        default: ;
      endcase
    end
  end

  // pipeline advance: stall only when a finished result cannot move into the output register
  tbc_tag_t div_tag [0:DIV_STEPS];
  logic     en;

  assign en = !div_tag[DIV_STEPS].valid || !result.valid || result.ready;
  assign sample.ready = en;

  // input step: fault screen and the two legs of the divider
  tbc_tag_t          in_tag;
  logic [VOLT_W-1:0] in_v, in_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_tag <= '0;
    end else if (en) begin
      in_tag.valid <= sample.valid;
      if (sample.bridge_voltage >= supply) begin
        in_tag.code <= FAULT_HIGH;
      end else if (sample.bridge_voltage == '0) begin
        in_tag.code <= FAULT_ZERO;
      end else begin
        in_tag.code <= FAULT_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_v <= sample.bridge_voltage;
      in_w <= supply - sample.bridge_voltage;
    end
  end

  // normalize each leg to a Q30 mantissa in [1,2) and its exponent
  function automatic tbc_log_t normalize(logic [VOLT_W-1:0] n);
    logic [K_W-1:0]    k;
    logic [MANT_W-1:0] ext;
    tbc_log_t          y;
    k = '0;
    for (int i = 1; i < VOLT_W; i++) begin
      if (n[i]) begin
        k = K_W'(i);
      end
    end
    ext = MANT_W'(n);
    y.k = k;
    y.frac = '0;
    y.m = ext << (K_W'(MANT_W - 1) - k);
    return y;
  endfunction

  tbc_tag_t log_tag [0:LOG_FRAC];
  tbc_log_t log_a [0:LOG_FRAC];
  tbc_log_t log_b [0:LOG_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      log_tag[0] <= '0;
    end else if (en) begin
      log_tag[0] <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      log_a[0] <= normalize(in_v);
      log_b[0] <= normalize(in_w);
    end
  end

  // one cell per fraction bit of log2, msb first
  for (genvar i = 0; i < LOG_FRAC; i++) begin : g_log
    tbc_log_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .tag_i (log_tag[i]),
      .a_i   (log_a[i]),
      .b_i   (log_b[i]),
      .tag_o (log_tag[i+1]),
      .a_o   (log_a[i+1]),
      .b_o   (log_b[i+1])
    );
  end

  // log2 v - log2 (supply - v), Q28
  tbc_tag_t             diff_tag;
  logic signed [LOG_W:0] diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_tag <= '0;
    end else if (en) begin
      diff_tag <= log_tag[LOG_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= $signed({1'b0, log_a[LOG_FRAC].k, log_a[LOG_FRAC].frac})
            - $signed({1'b0, log_b[LOG_FRAC].k, log_b[LOG_FRAC].frac});
    end
  end

  // x = diff * ln2, then horner over d, c, b, a; all four use the same cell
  tbc_tag_t              mac_tag [0:3];
  logic signed [63:0]    mac_t [0:3];
  logic signed [X_W-1:0] mac_x [0:3];

  tbc_mac_cell u_mac_x (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .tag_i (diff_tag),
    .t_i   (64'(diff)),
    .x_i   (X_W'(LN2_Q28)),
    .coef  ('0),
    .tag_o (mac_tag[0]),
    .t_o   (mac_t[0]),
    .x_o   (mac_x[0])
  );

  tbc_mac_cell u_mac_c (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .tag_i (mac_tag[0]),
    .t_i   (64'(coef_d)),
    .x_i   (mac_t[0][X_W-1:0]),
    .coef  (coef_c),
    .tag_o (mac_tag[1]),
    .t_o   (mac_t[1]),
    .x_o   (mac_x[1])
  );

  tbc_mac_cell u_mac_b (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .tag_i (mac_tag[1]),
    .t_i   (mac_t[1]),
    .x_i   (mac_x[1]),
    .coef  (coef_b),
    .tag_o (mac_tag[2]),
    .t_o   (mac_t[2]),
    .x_o   (mac_x[2])
  );

  tbc_mac_cell u_mac_a (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .tag_i (mac_tag[2]),
    .t_i   (mac_t[2]),
    .x_i   (mac_x[2]),
    .coef  (coef_a),
    .tag_o (mac_tag[3]),
    .t_o   (mac_t[3]),
    .x_o   (mac_x[3])
  );

  // denominator check: zero or negative saturates high
  tbc_div_t div_d [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_tag[0] <= '0;
    end else if (en) begin
      div_tag[0].valid <= mac_tag[3].valid;
      if (mac_tag[3].code == FAULT_NONE && (mac_t[3][63] || mac_t[3] == '0)) begin
        div_tag[0].code <= FAULT_SAT;
      end else begin
        div_tag[0].code <= mac_tag[3].code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_d[0].r   <= '0;
      div_d[0].d   <= mac_t[3][MAG_W-1:0];
      div_d[0].q   <= '0;
      div_d[0].sat <= 1'b0;
    end
  end

  // restoring division of 2^(coef+temp+1) by t, one quotient bit per cell
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    tbc_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .lead  (i == 0),
      .tag_i (div_tag[i]),
      .div_i (div_d[i]),
      .tag_o (div_tag[i+1]),
      .div_o (div_d[i+1])
    );
  end

  // round the quotient, drop to celsius, clamp
  tbc_div_t                 last;
  logic [QUOT_W:0]          q_inc;
  logic signed [41:0]       cel;
  logic signed [TEMP_W-1:0] temp_next;
  tbc_fault_t               fault_next;

  always_comb begin
    last = div_d[DIV_STEPS];
    q_inc = {1'b0, last.q} + (QUOT_W + 1)'(1);
    cel = $signed({2'b0, q_inc[QUOT_W:1]}) - KELVIN_OFF;
    temp_next = '0;
    fault_next = div_tag[DIV_STEPS].code;
    case (div_tag[DIV_STEPS].code)
      FAULT_HIGH, FAULT_ZERO: temp_next = '0;
      FAULT_SAT:              temp_next = TEMP_MAX;
      default: begin
        if (last.sat || cel > 42'(TEMP_MAX)) begin
          temp_next = TEMP_MAX;
          fault_next = FAULT_SAT;
        end else if (cel < 42'(TEMP_MIN)) begin
          temp_next = TEMP_MIN;
          fault_next = FAULT_SAT;
        end else begin
          temp_next = cel[TEMP_W-1:0];
        end
      end
    endcase
  end

  // output register: holds a result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en && div_tag[DIV_STEPS].valid) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && div_tag[DIV_STEPS].valid) begin
      result.temperature_q8 <= temp_next;
      result.fault <= fault_next;
    end
  end

endmodule

// ----- rtl/core/tbc_log_cell.sv -----
`timescale 1ns / 1ps

// one square-and-compare step of log2 on two lanes
module tbc_log_cell
  import tbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  tbc_tag_t tag_i,
  input  tbc_log_t a_i,
  input  tbc_log_t b_i,
  output tbc_tag_t tag_o,
  output tbc_log_t a_o,
  output tbc_log_t b_o
);

  function automatic tbc_log_t sq_step(tbc_log_t x);
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     s;
    tbc_log_t            y;
    sq = x.m * x.m;
    s = sq[2*MANT_W-1:MANT_W-1];
    y.k = x.k;
    y.frac = {x.frac[LOG_FRAC-2:0], s[MANT_W]};
    y.m = s[MANT_W] ? s[MANT_W:1] : s[MANT_W-1:0];
    return y;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_o <= '0;
    end else if (en) begin
      tag_o <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_o <= sq_step(a_i);
      b_o <= sq_step(b_i);
    end
  end

endmodule

// ----- rtl/core/tbc_mac_cell.sv -----
`timescale 1ns / 1ps

// t*x >> 28 rounded in magnitude, clamped, plus coefficient; four stages
module tbc_mac_cell
  import tbc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  tbc_tag_t                 tag_i,
  input  logic signed [63:0]       t_i,
  input  logic signed [X_W-1:0]    x_i,
  input  logic signed [COEF_W-1:0] coef,
  output tbc_tag_t                 tag_o,
  output logic signed [63:0]       t_o,
  output logic signed [X_W-1:0]    x_o
);

  tbc_tag_t tag1, tag2, tag3;

  logic                  neg1, neg2, neg3;
  logic [MAG_W-1:0]      mt1;
  logic [X_W-2:0]        mx1;
  logic signed [X_W-1:0] x1, x2, x3;
  logic [63:0]           plo2;
  logic [MAG_W-1:0]      phi2;
  logic [MAG_W-1:0]      mag3;

  logic [63:0]      t_abs;
  logic [X_W-1:0]   x_abs;
  logic [95:0]      sum;
  logic [67:0]      rnd;
  logic [MAG_W-1:0] mag_next;
  logic [63:0]      signed_mag;

  always_comb begin
    t_abs = t_i[63] ? 64'(-t_i) : 64'(t_i);
    x_abs = x_i[X_W-1] ? X_W'(-x_i) : X_W'(x_i);
    sum = {32'b0, plo2} + {1'b0, phi2, 32'b0} + (96'd1 << (LOG_FRAC - 1));
    rnd = sum[95:LOG_FRAC];
    mag_next = (rnd > 68'(MAG_LIM)) ? MAG_LIM : rnd[MAG_W-1:0];
    signed_mag = neg3 ? -{1'b0, mag3} : {1'b0, mag3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1  <= '0;
      tag2  <= '0;
      tag3  <= '0;
      tag_o <= '0;
    end else if (en) begin
      tag1  <= tag_i;
      tag2  <= tag1;
      tag3  <= tag2;
      tag_o <= tag3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= t_i[63] ^ x_i[X_W-1];
      mt1  <= t_abs[MAG_W-1:0];
      mx1  <= x_abs[X_W-2:0];
      x1   <= x_i;
      plo2 <= mt1[31:0] * mx1;
      phi2 <= mt1[MAG_W-1:32] * mx1;
      neg2 <= neg1;
      x2   <= x1;
      mag3 <= mag_next;
      neg3 <= neg2;
      x3   <= x2;
      t_o  <= $signed(signed_mag) + 64'(coef);
      x_o  <= x3;
    end
  end

endmodule

// ----- rtl/core/tbc_div_cell.sv -----
`timescale 1ns / 1ps

// one restoring division step with sticky quotient overflow
module tbc_div_cell
  import tbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     lead,
  input  tbc_tag_t tag_i,
  input  tbc_div_t div_i,
  output tbc_tag_t tag_o,
  output tbc_div_t div_o
);

  logic [MAG_W:0] r2;
  logic           ge;
  logic [MAG_W:0] diff;
  tbc_div_t       div_next;

  always_comb begin
    r2 = {div_i.r, lead};
    ge = r2 >= {1'b0, div_i.d};
    diff = r2 - {1'b0, div_i.d};
    div_next.d = div_i.d;
    div_next.r = ge ? diff[MAG_W-1:0] : r2[MAG_W-1:0];
    div_next.sat = div_i.sat | div_i.q[QUOT_W-1];
    div_next.q = div_i.sat ? div_i.q : {div_i.q[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_o <= '0;
    end else if (en) begin
      tag_o <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_o <= div_next;
    end
  end

endmodule

// ----- rtl/core/tbc_checker.sv -----
`timescale 1ns / 1ps

module tbc_checker
  import tbc_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [TEMP_W-1:0] temperature_q8,
  input logic [1:0]               fault
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(temperature_q8) && $stable(fault))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_input_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && (fault == FAULT_HIGH || fault == FAULT_ZERO) |-> temperature_q8 == '0)
    else $error("input fault with nonzero temperature");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault == FAULT_SAT |-> temperature_q8 == TEMP_MAX || temperature_q8 == TEMP_MIN)
    else $error("saturation fault off the bounds");

endmodule

bind thermistor_bridge_to_celsius tbc_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .temperature_q8 (result.temperature_q8),
  .fault          (result.fault)
);
